// ===== hdl/swlm_pkg.sv =====
`timescale 1ns / 1ps

package swlm_pkg;

  localparam int CoordBits          = 24;
  localparam int OutBits            = 24;
  localparam int WindowDepthDefault = 64;
  localparam int MinStepReset       = 102;
  localparam int WindowLenReset     = 32;
  localparam int MinPairs           = 3;
  localparam int DivSteps           = 25;

  localparam logic [127:0] SingLimit = 128'd1099512;

  localparam logic RegMinStep   = 1'b0;
  localparam logic RegWindowLen = 1'b1;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_CLOSE = 3'd1,
    STAT_FEW   = 3'd2,
    STAT_SING  = 3'd3,
    STAT_REJ   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_ACC_GO,
    S_ACC,
    S_SOLVE,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    V_IDLE,
    V_MUL_GO,
    V_MUL_WAIT,
    V_SING,
    V_DIV_GO,
    V_DIV_WAIT,
    V_CHK,
    V_DONE
  } solve_state_t;

  typedef struct packed {
    logic signed [63:0] sxx;
    logic signed [63:0] sxy;
    logic signed [63:0] syy;
    logic signed [63:0] bxx;
    logic signed [63:0] byx;
    logic signed [63:0] bxy;
    logic signed [63:0] byy;
  } sums_t;

endpackage

// ===== hdl/sliding_window_linear_map_fit_top.sv =====
`timescale 1ns / 1ps
// One item at a time; a result waiting on m_axis_tready holds off the next item.
// Dropped and short-window items give their result without accumulation; the next item
// is taken once that result has been loaded to the output. A fit over n pairs reads the
// n pairs through the accumulation pipeline, then forms fourteen 64x64 products on a
// four-slice multiplier and four divisions; a singular fit stops before the divisions.
// Synchronous reset empties the window, loads min_step 102, window_length 32; memory kept.

module sliding_window_linear_map_fit_top #(
  parameter int WINDOW_DEPTH = swlm_pkg::WindowDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // src_x, src_y, tgt_x, tgt_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata,  // m00, m01, m10, m11, anchor_src_x/y, anchor_tgt_x/y
  output logic [3:0]   m_axis_tuser   // fit_ok, status
);

  localparam int CB = swlm_pkg::CoordBits;
  localparam int OB = swlm_pkg::OutBits;
  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  swlm_pkg::ctrl_state_t state, state_next;

  logic [15:0]    min_step;
  logic [6:0]     window_length;
  logic [CW-1:0]  pair_count, pair_count_next, wl_eff;
  logic [CW:0]    count_inc;
  logic [AW-1:0]  write_slot, newest;
  logic [CB-1:0]  last_sx, last_sy;
  logic [4*CB-1:0] item;
  logic           cfg_wr;

  logic signed [CB:0] dx, dy;
  logic [CB:0]    adx, ady;
  logic [31:0]    sqx, sqy;
  logic [32:0]    sq_sum, sq_lim;
  logic           close;

  logic           store_we, store_start, store_done;
  swlm_pkg::sums_t sums;
  logic           solve_start, solve_done;
  swlm_pkg::status_t solve_status;
  logic [3:0][OB-1:0] solve_m;

  logic           load_out;
  swlm_pkg::status_t res_status;
  logic [3:0][OB-1:0] res_m;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      swlm_pkg::RegMinStep:   prdata = 32'(min_step);
      swlm_pkg::RegWindowLen: prdata = 32'(window_length);
      default:                prdata = '0;
    endcase
  end

  assign wl_eff    = (32'(window_length) > WINDOW_DEPTH) ? CW'(WINDOW_DEPTH)
                                                        : CW'(window_length);
  assign count_inc = (CW + 1)'(pair_count) + 1'b1;
  assign pair_count_next = (count_inc > (CW + 1)'(wl_eff)) ? wl_eff : count_inc[CW-1:0];

  assign dx     = $signed({item[CB-1], item[CB-1:0]}) - $signed({last_sx[CB-1], last_sx});
  assign dy     = $signed({item[2*CB-1], item[2*CB-1:CB]}) - $signed({last_sy[CB-1], last_sy});
  assign adx    = dx[CB] ? (CB + 1)'(-dx) : (CB + 1)'(dx);
  assign ady    = dy[CB] ? (CB + 1)'(-dy) : (CB + 1)'(dy);
  assign sqx    = 32'(adx[15:0]) * 32'(adx[15:0]);
  assign sqy    = 32'(ady[15:0]) * 32'(ady[15:0]);
  assign sq_sum = 33'(sqx) + 33'(sqy);
  assign sq_lim = 33'(32'(min_step) * 32'(min_step));
  assign close  = (pair_count != '0) && (adx < (CB + 1)'(min_step))
               && (ady < (CB + 1)'(min_step)) && (sq_sum < sq_lim);

  assign s_axis_tready = (state == swlm_pkg::S_IDLE);

  swlm_store #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .AW           (AW),
    .CW           (CW)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .we     (store_we),
    .waddr  (write_slot),
    .wdata  (item),
    .start  (store_start),
    .count  (pair_count),
    .newest (newest),
    .anchor (item),
    .done   (store_done),
    .sums   (sums)
  );

  swlm_solve u_solve (
    .clk    (clk),
    .rst    (rst),
    .start  (solve_start),
    .sums   (sums),
    .done   (solve_done),
    .status (solve_status),
    .m      (solve_m)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swlm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    store_we    = 1'b0;
    store_start = 1'b0;
    solve_start = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      swlm_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_next = swlm_pkg::S_CHECK;
      end
      swlm_pkg::S_CHECK: begin
        priority if (close) begin
          state_next = swlm_pkg::S_FINISH;
        end else if (32'(pair_count_next) < swlm_pkg::MinPairs) begin
          store_we   = 1'b1;
          state_next = swlm_pkg::S_FINISH;
        end else begin
          store_we   = 1'b1;
          state_next = swlm_pkg::S_ACC_GO;
        end
      end
      swlm_pkg::S_ACC_GO: begin
        store_start = 1'b1;
        state_next  = swlm_pkg::S_ACC;
      end
      swlm_pkg::S_ACC: begin
        if (store_done) begin
          solve_start = 1'b1;
          state_next  = swlm_pkg::S_SOLVE;
        end
      end
      swlm_pkg::S_SOLVE: begin
        if (solve_done) state_next = swlm_pkg::S_FINISH;
      end
      swlm_pkg::S_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = swlm_pkg::S_IDLE;
        end
      end
      default: state_next = swlm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step      <= 16'(swlm_pkg::MinStepReset);
      window_length <= 7'(swlm_pkg::WindowLenReset);
      pair_count    <= '0;
      write_slot    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          swlm_pkg::RegMinStep:   min_step <= pwdata[15:0];
          swlm_pkg::RegWindowLen: window_length <= pwdata[6:0];
          default: ;
        endcase
      end
      if (store_we) begin
        pair_count <= pair_count_next;
        write_slot <= (write_slot == AW'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= s_axis_tdata;
    end
    if (store_we) begin
      newest  <= write_slot;
      last_sx <= item[CB-1:0];
      last_sy <= item[2*CB-1:CB];
    end
    if (state == swlm_pkg::S_CHECK) begin
      res_m      <= '0;
      res_status <= close ? swlm_pkg::STAT_CLOSE : swlm_pkg::STAT_FEW;
    end
    if (state == swlm_pkg::S_SOLVE && solve_done) begin
      res_m      <= solve_m;
      res_status <= solve_status;
    end
    if (load_out) begin
      m_axis_tuser <= {res_status, res_status == swlm_pkg::STAT_OK};
      m_axis_tdata[4*OB-1:0] <= res_m;
      m_axis_tdata[8*OB-1:4*OB] <= (res_status == swlm_pkg::STAT_CLOSE
                                    || res_status == swlm_pkg::STAT_FEW) ? '0 : item;
    end
  end

endmodule

// ===== hdl/swlm_store.sv =====
`timescale 1ns / 1ps

module swlm_store #(
  parameter int WINDOW_DEPTH = swlm_pkg::WindowDepthDefault,
  parameter int AW = $clog2(WINDOW_DEPTH),
  parameter int CW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic [4*swlm_pkg::CoordBits-1:0]    wdata,
  input  logic                                start,
  input  logic [CW-1:0]                       count,
  input  logic [AW-1:0]                       newest,
  input  logic [4*swlm_pkg::CoordBits-1:0]    anchor,
  output logic                                done,
  output swlm_pkg::sums_t                     sums
);

  localparam int CB = swlm_pkg::CoordBits;

  logic [4*CB-1:0] mem [WINDOW_DEPTH];
  logic [4*CB-1:0] rdata;
  logic [AW-1:0]   raddr;
  logic [CW-1:0]   left;
  logic            busy;
  logic            issue;
  logic            rd_v;
  logic            df_v;
  logic            pr_v;

  logic signed [CB:0]     ux, uy, vx, vy;
  logic signed [2*CB+1:0] p_xx, p_xy, p_yy, p_bxx, p_byx, p_bxy, p_byy;

  assign issue = busy && (left != '0);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      left <= '0;
      raddr <= '0;
      rd_v <= 1'b0;
      df_v <= 1'b0;
      pr_v <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      rd_v <= issue;
      df_v <= rd_v;
      pr_v <= df_v;
      if (start) begin
        busy <= 1'b1;
        left <= count;
        raddr <= newest;
      end else if (issue) begin
        left <= left - 1'b1;
        raddr <= (raddr == '0) ? AW'(WINDOW_DEPTH - 1) : raddr - 1'b1;
      end else if (busy && !rd_v && !df_v && !pr_v) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // differences to the newest pair, then the seven products, then the sums
  always_ff @(posedge clk) begin
    ux <= $signed({rdata[CB-1], rdata[CB-1:0]})
        - $signed({anchor[CB-1], anchor[CB-1:0]});
    uy <= $signed({rdata[2*CB-1], rdata[2*CB-1:CB]})
        - $signed({anchor[2*CB-1], anchor[2*CB-1:CB]});
    vx <= $signed({rdata[3*CB-1], rdata[3*CB-1:2*CB]})
        - $signed({anchor[3*CB-1], anchor[3*CB-1:2*CB]});
    vy <= $signed({rdata[4*CB-1], rdata[4*CB-1:3*CB]})
        - $signed({anchor[4*CB-1], anchor[4*CB-1:3*CB]});
    p_xx  <= ux * ux;
    p_xy  <= ux * uy;
    p_yy  <= uy * uy;
    p_bxx <= ux * vx;
    p_byx <= uy * vx;
    p_bxy <= ux * vy;
    p_byy <= uy * vy;
    if (start) begin
      sums <= '0;
    end else if (pr_v) begin
      sums.sxx <= sums.sxx + 64'(p_xx);
      sums.sxy <= sums.sxy + 64'(p_xy);
      sums.syy <= sums.syy + 64'(p_yy);
      sums.bxx <= sums.bxx + 64'(p_bxx);
      sums.byx <= sums.byx + 64'(p_byx);
      sums.bxy <= sums.bxy + 64'(p_bxy);
      sums.byy <= sums.byy + 64'(p_byy);
    end
  end

endmodule

// ===== hdl/swlm_mul.sv =====
`timescale 1ns / 1ps

module swlm_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [63:0]  a,
  input  logic signed [63:0]  b,
  output logic                done,
  output logic signed [127:0] p
);

  logic [63:0]  ma, mb;
  logic         neg;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         ppv;
  logic [31:0]  op_a, op_b;
  logic [1:0]   shamt;

  assign op_a  = cnt[1] ? ma[63:32] : ma[31:0];
  assign op_b  = cnt[0] ? mb[63:32] : mb[31:0];
  assign shamt = {1'b0, pp_sh[1]} + {1'b0, pp_sh[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ppv <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        ppv <= 1'b0;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          ppv <= 1'b1;
          cnt <= cnt + 1'b1;
        end else begin
          ppv <= 1'b0;
          if (!ppv) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[63] ? 64'(-a) : 64'(a);
      mb  <= b[63] ? 64'(-b) : 64'(b);
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else begin
      pp    <= 64'(op_a) * 64'(op_b);
      pp_sh <= cnt[1:0];
      if (ppv) begin
        acc <= acc + (128'(pp) << {shamt, 5'b0});
      end
      if (busy && cnt == 3'd4 && !ppv) begin
        p <= neg ? -$signed(acc) : $signed(acc);
      end
    end
  end

endmodule

// ===== hdl/swlm_div.sv =====
`timescale 1ns / 1ps

module swlm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [127:0]               n,
  input  logic [127:0]                      d,
  output logic                              done,
  output logic signed [swlm_pkg::OutBits-1:0] q
);

  localparam int RW = 136;
  localparam int OB = swlm_pkg::OutBits;

  logic [RW-1:0] r, dsh, dd;
  logic [RW-1:0] cmp_val, cmp_ref;
  logic [127:0]  mag;
  logic          neg;
  logic          sat;
  logic          busy;
  logic [4:0]    step;
  logic [24:0]   qb;
  logic          ge;
  logic [25:0]   qfull;
  logic [24:0]   rnd;

  assign mag     = n[127] ? 128'(-n) : 128'(n);
  assign cmp_val = (step < 5'd8) ? r : (r << 1);
  assign cmp_ref = (step < 5'd8) ? dsh : dd;
  assign ge      = cmp_val >= cmp_ref;
  assign qfull   = sat ? 26'(1 << 25) : {1'b0, qb};
  assign rnd     = 25'((qfull + 26'd1) >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= (RW'(mag) >= (RW'(d) << 8)) ? 5'(swlm_pkg::DivSteps) : 5'd0;
      end else if (busy) begin
        if (step == 5'(swlm_pkg::DivSteps)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= RW'(mag);
      dd  <= RW'(d);
      dsh <= RW'(d) << 7;
      neg <= n[127];
      sat <= RW'(mag) >= (RW'(d) << 8);
      qb  <= '0;
    end else if (busy) begin
      if (step != 5'(swlm_pkg::DivSteps)) begin
        r  <= ge ? cmp_val - cmp_ref : cmp_val;
        qb <= {qb[23:0], ge};
        if (step < 5'd7) begin
          dsh <= dsh >> 1;
        end
      end else if (!neg) begin
        q <= (rnd > 25'd8388607) ? OB'(8388607) : OB'(rnd);
      end else begin
        q <= (rnd > 25'd8388608) ? OB'(-8388608) : OB'(-$signed({1'b0, rnd}));
      end
    end
  end

endmodule

// ===== hdl/swlm_solve.sv =====
`timescale 1ns / 1ps

module swlm_solve (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  swlm_pkg::sums_t                        sums,
  output logic                                   done,
  output swlm_pkg::status_t                      status,
  output logic [3:0][swlm_pkg::OutBits-1:0]      m
);

  localparam int OB = swlm_pkg::OutBits;

  swlm_pkg::solve_state_t state, state_next;

  logic [3:0]          idx;
  logic [1:0]          dj;
  logic signed [63:0]  op_a, op_b;
  logic                mul_start, mul_done;
  logic signed [127:0] mul_p;
  logic                div_start, div_done;
  logic signed [OB-1:0] div_q;
  logic signed [127:0] tmp;
  logic signed [127:0] nums [7];
  logic                singular;
  logic [63:0]         dq_mag, oq_mag;
  logic signed [63:0]  dq_lo, oq_lo;

  assign singular = nums[0][127] || ($unsigned(nums[0]) < swlm_pkg::SingLimit);
  assign dq_lo    = nums[5][63:0];
  assign oq_lo    = nums[6][63:0];
  assign dq_mag   = dq_lo[63] ? 64'(-dq_lo) : 64'(dq_lo);
  assign oq_mag   = oq_lo[63] ? 64'(-oq_lo) : 64'(oq_lo);

  always_comb begin
    unique case (idx)
      4'd0:    begin op_a = sums.sxx; op_b = sums.syy; end
      4'd1:    begin op_a = sums.sxy; op_b = sums.sxy; end
      4'd2:    begin op_a = sums.syy; op_b = sums.bxx; end
      4'd3:    begin op_a = sums.sxy; op_b = sums.byx; end
      4'd4:    begin op_a = sums.sxx; op_b = sums.byx; end
      4'd5:    begin op_a = sums.sxy; op_b = sums.bxx; end
      4'd6:    begin op_a = sums.syy; op_b = sums.bxy; end
      4'd7:    begin op_a = sums.sxy; op_b = sums.byy; end
      4'd8:    begin op_a = sums.sxx; op_b = sums.byy; end
      4'd9:    begin op_a = sums.sxy; op_b = sums.bxy; end
      4'd10:   begin op_a = 64'($signed(m[0])); op_b = 64'($signed(m[3])); end
      4'd11:   begin op_a = 64'($signed(m[2])); op_b = 64'($signed(m[1])); end
      4'd12:   begin op_a = 64'($signed(m[0])); op_b = 64'($signed(m[1])); end
      4'd13:   begin op_a = 64'($signed(m[2])); op_b = 64'($signed(m[3])); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  swlm_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  swlm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (nums[3'(dj) + 3'd1]),
    .d     ($unsigned(nums[0])),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swlm_pkg::V_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    done       = 1'b0;
    unique case (state)
      swlm_pkg::V_IDLE: begin
        if (start) state_next = swlm_pkg::V_MUL_GO;
      end
      swlm_pkg::V_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = swlm_pkg::V_MUL_WAIT;
      end
      swlm_pkg::V_MUL_WAIT: begin
        if (mul_done) begin
          priority if (idx == 4'd9) state_next = swlm_pkg::V_SING;
          else if (idx == 4'd13) state_next = swlm_pkg::V_CHK;
          else state_next = swlm_pkg::V_MUL_GO;
        end
      end
      swlm_pkg::V_SING: begin
        state_next = singular ? swlm_pkg::V_DONE : swlm_pkg::V_DIV_GO;
      end
      swlm_pkg::V_DIV_GO: begin
        div_start  = 1'b1;
        state_next = swlm_pkg::V_DIV_WAIT;
      end
      swlm_pkg::V_DIV_WAIT: begin
        if (div_done) begin
          state_next = (dj == 2'd3) ? swlm_pkg::V_MUL_GO : swlm_pkg::V_DIV_GO;
        end
      end
      swlm_pkg::V_CHK: begin
        state_next = swlm_pkg::V_DONE;
      end
      swlm_pkg::V_DONE: begin
        done       = 1'b1;
        state_next = swlm_pkg::V_IDLE;
      end
      default: state_next = swlm_pkg::V_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx <= '0;
      dj  <= '0;
    end
    if (state == swlm_pkg::V_MUL_WAIT && mul_done) begin
      if (!idx[0]) begin
        tmp <= mul_p;
      end else begin
        nums[idx[3:1]] <= (idx == 4'd13) ? tmp + mul_p : tmp - mul_p;
      end
      idx <= idx + 1'b1;
    end
    if (state == swlm_pkg::V_SING && singular) begin
      m      <= '0;
      status <= swlm_pkg::STAT_SING;
    end
    if (state == swlm_pkg::V_DIV_WAIT && div_done) begin
      m[dj] <= div_q;
      dj    <= dj + 1'b1;
    end
    if (state == swlm_pkg::V_CHK) begin
      status <= (dq_mag > 64'(1) << 30 && dq_mag < 64'(1) << 34 && oq_mag < 64'(1) << 33)
              ? swlm_pkg::STAT_OK : swlm_pkg::STAT_REJ;
    end
  end

endmodule

// ===== tb/sv/tb_sliding_window_linear_map_fit_top.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_linear_map_fit_top;

  localparam int Depth = 64;
  localparam logic [2:0] AddrMinStep = {swlm_pkg::RegMinStep, 2'b00};
  localparam logic [2:0] AddrWinLen  = {swlm_pkg::RegWindowLen, 2'b00};
  localparam int SettleCycles = 400;

  typedef struct {
    logic              fit_ok;
    swlm_pkg::status_t status;
    logic [23:0]       m [4];
    logic [23:0]       anc [4];
  } fit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // src_x, src_y, tgt_x, tgt_y
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;      // m00, m01, m10, m11, anchor_src_x/y, anchor_tgt_x/y
  logic [3:0] m_axis_tuser;        // fit_ok, status

  sliding_window_linear_map_fit_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  longint pair_sx [Depth], pair_sy [Depth], pair_tx [Depth], pair_ty [Depth];
  int unsigned pair_cnt, wslot, min_step, win_len;

  fit_t fits_due [$];
  int fails;
  int send_idle, recv_idle;

  // path generator state
  longint path_x, path_y;
  longint map_a, map_b, map_c, map_d, map_ox, map_oy;

  function automatic longint clamp_diff(longint v);
    if (v > 16777215) return 16777215;
    if (v < -16777215) return -16777215;
    return v;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sext24(longint v);
    return longint'($signed(v[23:0]));
  endfunction

  function automatic longint ratio_q16(logic signed [127:0] n, logic signed [127:0] d);
    logic [127:0] mag, den, q, r;
    den = d;
    mag = (n < 0) ? -n : n;
    if (mag >= (den << 8)) q = 128'd1 << 25;
    else q = (mag << 17) / den;
    r = (q + 1) >> 1;
    if (n >= 0) return (r > 8388607) ? 8388607 : longint'(r);
    return (r > 8388608) ? -8388608 : -longint'(r);
  endfunction

  function automatic fit_t fit_predict(longint sx, longint sy, longint tx, longint ty);
    fit_t f;
    int unsigned last, newest, wl, k;
    longint dx, dy, ux, uy, vx, vy;
    longint sxx, sxy, syy, bxx, byx, bxy, byy, dq, oq;
    longint mq [4];
    logic signed [127:0] w_xx, w_xy, w_yy, w_bxx, w_byx, w_bxy, w_byy, det;
    sx = sext24(sx); sy = sext24(sy); tx = sext24(tx); ty = sext24(ty);
    f.fit_ok = 1'b0;
    f.status = swlm_pkg::STAT_CLOSE;
    for (int i = 0; i < 4; i++) begin
      f.m[i] = '0;
      f.anc[i] = '0;
    end
    if (pair_cnt > 0) begin
      last = (wslot == 0) ? Depth - 1 : wslot - 1;
      dx = labs(sx - pair_sx[last]);
      dy = labs(sy - pair_sy[last]);
      if (dx < min_step && dy < min_step && dx * dx + dy * dy < longint'(min_step) * min_step)
        return f;
    end
    newest = wslot;
    pair_sx[newest] = sx; pair_sy[newest] = sy;
    pair_tx[newest] = tx; pair_ty[newest] = ty;
    wslot = (newest + 1) % Depth;
    wl = (win_len > Depth) ? Depth : win_len;
    pair_cnt = (pair_cnt + 1 > wl) ? wl : pair_cnt + 1;
    if (pair_cnt < 3) begin
      f.status = swlm_pkg::STAT_FEW;
      return f;
    end
    f.anc[0] = sx[23:0]; f.anc[1] = sy[23:0]; f.anc[2] = tx[23:0]; f.anc[3] = ty[23:0];
    sxx = 0; sxy = 0; syy = 0; bxx = 0; byx = 0; bxy = 0; byy = 0;
    k = newest;
    for (int i = 0; i < pair_cnt; i++) begin
      ux = clamp_diff(pair_sx[k] - sx); uy = clamp_diff(pair_sy[k] - sy);
      vx = clamp_diff(pair_tx[k] - tx); vy = clamp_diff(pair_ty[k] - ty);
      sxx += ux * ux; sxy += ux * uy; syy += uy * uy;
      bxx += ux * vx; byx += uy * vx; bxy += ux * vy; byy += uy * vy;
      k = (k == 0) ? Depth - 1 : k - 1;
    end
    w_xx = sxx; w_xy = sxy; w_yy = syy;
    w_bxx = bxx; w_byx = byx; w_bxy = bxy; w_byy = byy;
    det = w_xx * w_yy - w_xy * w_xy;
    if (det < 0 || det < 128'sd1099512) begin
      f.status = swlm_pkg::STAT_SING;
      return f;
    end
    mq[0] = ratio_q16(w_yy * w_bxx - w_xy * w_byx, det);
    mq[1] = ratio_q16(w_xx * w_byx - w_xy * w_bxx, det);
    mq[2] = ratio_q16(w_yy * w_bxy - w_xy * w_byy, det);
    mq[3] = ratio_q16(w_xx * w_byy - w_xy * w_bxy, det);
    for (int i = 0; i < 4; i++) f.m[i] = mq[i][23:0];
    dq = mq[0] * mq[3] - mq[2] * mq[1];
    oq = mq[0] * mq[1] + mq[2] * mq[3];
    if (labs(dq) > (64'sd1 << 30) && labs(dq) < (64'sd1 << 34) && labs(oq) < (64'sd1 << 33)) begin
      f.status = swlm_pkg::STAT_OK;
      f.fit_ok = 1'b1;
    end else begin
      f.status = swlm_pkg::STAT_REJ;
    end
    return f;
  endfunction

  task automatic send_pair(longint sx, longint sy, longint tx, longint ty);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata = {ty[23:0], tx[23:0], sy[23:0], sx[23:0]};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    fits_due = {fits_due, fit_predict(sx, sy, tx, ty)};
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (fits_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = value; penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    if (addr == AddrMinStep) min_step = value[15:0];
    else win_len = value[6:0];
  endtask

  task automatic set_config(int unsigned step, int unsigned wlen);
    drain();
    write_reg(AddrMinStep, step);
    write_reg(AddrWinLen, wlen);
  endtask

  function automatic longint sat24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic new_map;
    map_a = longint'($urandom_range(0, 180000)) - 90000;
    map_b = longint'($urandom_range(0, 180000)) - 90000;
    map_c = longint'($urandom_range(0, 180000)) - 90000;
    map_d = longint'($urandom_range(0, 180000)) - 90000;
    map_ox = longint'($urandom_range(0, 200000)) - 100000;
    map_oy = longint'($urandom_range(0, 200000)) - 100000;
  endtask

  // mostly a mapped path spaced past min_step, some near repeats and raw noise
  task automatic send_path_item;
    longint step, tx, ty;
    int pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_pair($urandom, $urandom, $urandom, $urandom);
    end else begin
      if (pick < 20) step = $urandom_range(0, min_step);
      else step = min_step + $urandom_range(0, 4 * min_step + 2000);
      path_x += $urandom_range(1) ? step : -step;
      path_y += longint'($urandom_range(0, 2 * step)) - step;
      if (labs(path_x) > 6000000 || labs(path_y) > 6000000) begin
        path_x = longint'($urandom_range(0, 200000)) - 100000;
        path_y = longint'($urandom_range(0, 200000)) - 100000;
      end
      tx = sat24(((map_a * path_x + map_b * path_y) >>> 16) + map_ox + $urandom_range(0, 8));
      ty = sat24(((map_c * path_x + map_d * path_y) >>> 16) + map_oy + $urandom_range(0, 8));
      send_pair(path_x, path_y, tx, ty);
    end
  endtask

  always @(negedge clk) m_axis_tready = ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    fit_t f;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (fits_due.size() == 0) begin
        $display("%0t: unexpected result tuser %h tdata %h", $time, m_axis_tuser, m_axis_tdata);
        fails++;
      end else begin
        f = fits_due.pop_front();
        if (m_axis_tuser[0] !== f.fit_ok) begin
          $display("%0t: fit_ok expected %b actual %b", $time, f.fit_ok, m_axis_tuser[0]);
          fails++;
        end
        if (m_axis_tuser[3:1] !== f.status) begin
          $display("%0t: status expected %0d actual %0d", $time, f.status, m_axis_tuser[3:1]);
          fails++;
        end
        for (int i = 0; i < 4; i++) begin
          if (m_axis_tdata[24*i +: 24] !== f.m[i]) begin
            $display("%0t: m[%0d] expected %h actual %h", $time, i, f.m[i],
                     m_axis_tdata[24*i +: 24]);
            fails++;
          end
          if (m_axis_tdata[96 + 24*i +: 24] !== f.anc[i]) begin
            $display("%0t: anchor[%0d] expected %h actual %h", $time, i, f.anc[i],
                     m_axis_tdata[96 + 24*i +: 24]);
            fails++;
          end
        end
      end
    end
  end

  task automatic test_directed;
    send_pair(0, 0, 0, 0);
    send_pair(50, 50, 7, 7);                  // too close
    send_pair(2000, 0, 0, 2000);
    send_pair(0, 2000, -2000, 0);             // quarter turn fit
    send_pair(-3000, -1000, 1000, -3000);
    send_pair(9000, 0, 27000, 0);             // scaled pair, fit rejected
    send_pair(8388607, -8388608, -8388608, 8388607);
    send_pair(-8388608, 8388607, 8388607, -8388608);
    send_pair(8388607, 8388607, 8388607, 8388607);
    set_config(10, 3);
    send_pair(10000, 0, 0, 0);
    send_pair(20000, 0, 10, 0);
    send_pair(30000, 0, 20, 0);               // collinear, singular
    send_pair(30009, 0, 0, 0);                // just inside spacing
    send_pair(30007, 7, 0, 0);                // diagonal distance just under 10
    send_pair(30007, 8, 1, 1);
    set_config(65535, 64);
    send_pair(0, 0, 0, 0);
    send_pair(65534, 0, 0, 0);
    send_pair(0, 65535, 5, 5);
  endtask

  task automatic test_window_edges;
    set_config(102, 0);                       // empty window, never spacing tested
    send_pair(0, 0, 0, 0);
    send_pair(0, 0, 0, 0);
    set_config(102, 127);
    for (int i = 0; i < 70; i++) send_path_item();
    set_config(200, 3);                       // shrink at next stored pair
    for (int i = 0; i < 10; i++) send_path_item();
  endtask

  task automatic test_random(int unsigned step, int unsigned wlen, int n);
    set_config(step, wlen);
    new_map();
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 59) new_map();
      if (i == n / 2) while (fits_due.size() != 0) @(negedge clk);
      send_path_item();
    end
  endtask

  initial begin
    fails = 0;
    pair_cnt = 0; wslot = 0;
    min_step = swlm_pkg::MinStepReset; win_len = swlm_pkg::WindowLenReset;
    path_x = 0; path_y = 0;
    send_idle = 14; recv_idle = 45;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    new_map();
    test_window_edges();
    test_random(102, 32, 170);
    send_idle = 45; recv_idle = 14;
    test_random(10, 3, 170);
    test_random(65535, 64, 60);
    send_idle = 0; recv_idle = 0;
    test_random(500, 8, 170);
    drain();
    if (fails == 0) $display("sliding_window_linear_map_fit_top: match");
    else $display("sliding_window_linear_map_fit_top: mismatch");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("sliding_window_linear_map_fit_top: mismatch");
    $finish;
  end

endmodule
